FILE: rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared constants and types for the sorted key table
// Table sizes, field widths, request codes and the controller/datapath
// command and status records.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int DEPTH       = 64;
    localparam int KEY_BYTES   = 4;

    localparam int ACT_W       = 3;
    localparam int POS_W       = 7;
    localparam int KEY_FIELD_W = 32;
    localparam int WHERE_W     = 7;
    localparam int TOTAL_W     = 7;

    localparam int KEY_W = (8 * KEY_BYTES < KEY_FIELD_W) ? 8 * KEY_BYTES : KEY_FIELD_W;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef logic [ACT_W-1:0]       action_t;
    typedef logic [POS_W-1:0]       pos_t;
    typedef logic [KEY_FIELD_W-1:0] key_field_t;
    typedef logic [KEY_W-1:0]       key_t;
    typedef logic [WHERE_W-1:0]     where_t;
    typedef logic [TOTAL_W-1:0]     total_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [CMP_W-1:0]       cmp_t;

    localparam action_t ACT_APPEND    = 3'd0;
    localparam action_t ACT_INS_AT    = 3'd1;
    localparam action_t ACT_INS_SORT  = 3'd2;
    localparam action_t ACT_INS_UNIQ  = 3'd3;
    localparam action_t ACT_REMOVE    = 3'd4;
    localparam action_t ACT_READ      = 3'd5;
    localparam action_t ACT_SEARCH    = 3'd6;
    localparam action_t ACT_CLEAR     = 3'd7;

    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] dp_op_t;

    localparam dp_op_t OP_NONE      = 4'd0;
    localparam dp_op_t OP_LATCH     = 4'd1;
    localparam dp_op_t OP_DECODE    = 4'd2;
    localparam dp_op_t OP_SRCH_ADDR = 4'd3;
    localparam dp_op_t OP_SRCH_CMP  = 4'd4;
    localparam dp_op_t OP_SRCH_DONE = 4'd5;
    localparam dp_op_t OP_UP_RD     = 4'd6;
    localparam dp_op_t OP_UP_WR     = 4'd7;
    localparam dp_op_t OP_INS_WR    = 4'd8;
    localparam dp_op_t OP_DN_RD     = 4'd9;
    localparam dp_op_t OP_DN_WR     = 4'd10;
    localparam dp_op_t OP_REM_END   = 4'd11;
    localparam dp_op_t OP_RD_ADDR   = 4'd12;
    localparam dp_op_t OP_RD_CAP    = 4'd13;
    localparam dp_op_t OP_OUT_LOAD  = 4'd14;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        action_t act;
        logic    dec_err;
        logic    full;
        logic    need_ins;
        logic    srch_open;
        logic    srch_hit;
        logic    up_more;
        logic    dn_more;
    } dp_sts_t;

endpackage

FILE: rtl/core/skt_if.sv
// ----------------------------------------------------------------------------
// skt_if: request and result channels of the sorted key table
// Valid/ready channels, a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface skt_req_if;
    logic                valid;
    logic                ready;
    skt_pkg::action_t    action;
    skt_pkg::pos_t       position;
    skt_pkg::key_field_t key;

    modport source (output valid, output action, output position, output key, input ready);
    modport sink   (input valid, input action, input position, input key, output ready);
endinterface

interface skt_rsp_if;
    logic                valid;
    logic                ready;
    logic                status;
    logic                found;
    skt_pkg::where_t     where_index;
    skt_pkg::key_field_t read_key;
    skt_pkg::total_t     entry_total;

    modport source (output valid, output status, output found, output where_index,
                    output read_key, output entry_total, input ready);
    modport sink   (input valid, input status, input found, input where_index,
                    input read_key, input entry_total, output ready);
endinterface

FILE: rtl/core/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/skt_datapath.sv
// ----------------------------------------------------------------------------
// skt_datapath: key store, search bounds, shift pointer and result words
// Acts on one command per cycle from the controller and reports flags back.
// ----------------------------------------------------------------------------
module skt_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  skt_pkg::dp_cmd_t    cmd,
    output skt_pkg::dp_sts_t    sts,
    input  skt_pkg::action_t    in_action,
    input  skt_pkg::pos_t       in_position,
    input  skt_pkg::key_field_t in_key,
    output logic                out_status,
    output logic                out_found,
    output skt_pkg::where_t     out_where,
    output skt_pkg::key_field_t out_read_key,
    output skt_pkg::total_t     out_total
);

    skt_pkg::action_t    act_reg, act_next;
    skt_pkg::pos_t       pos_reg, pos_next;
    skt_pkg::key_t       key_reg, key_next;
    skt_pkg::cnt_t       count_reg, count_next;
    skt_pkg::cnt_t       lo_reg, lo_next;
    skt_pkg::cnt_t       hi_reg, hi_next;
    skt_pkg::cnt_t       idx_reg, idx_next;
    skt_pkg::cmp_t       where_reg, where_next;
    logic                status_reg, status_next;
    logic                hit_reg, hit_next;
    skt_pkg::key_t       rkey_reg, rkey_next;

    logic                out_status_reg;
    logic                out_found_reg;
    skt_pkg::where_t     out_where_reg;
    skt_pkg::key_field_t out_read_key_reg;
    skt_pkg::total_t     out_total_reg;

    logic                wr_en;
    skt_pkg::idx_t       wr_addr;
    skt_pkg::key_t       wr_data;
    logic                rd_en;
    skt_pkg::idx_t       rd_addr;
    skt_pkg::key_t       rd_data;

    skt_pkg::cmp_t       pos_ext;
    skt_pkg::cmp_t       cnt_ext;
    skt_pkg::cmp_t       idx_ext;
    logic [skt_pkg::CNT_W:0] mid_sum;
    logic [skt_pkg::CNT_W:0] idx_inc;
    skt_pkg::cnt_t       mid;
    logic                full;
    logic                dec_err;
    logic                need_ins;
    logic                key_eq;
    logic                key_lt;

    skt_ram #(
        .WIDTH (skt_pkg::KEY_W),
        .DEPTH (skt_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pos_ext  = skt_pkg::cmp_t'(pos_reg);
    assign cnt_ext  = skt_pkg::cmp_t'(count_reg);
    assign idx_ext  = skt_pkg::cmp_t'(idx_reg);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[skt_pkg::CNT_W:1];
    assign idx_inc  = {1'b0, idx_reg} + 1'b1;
    assign full     = (count_reg == skt_pkg::CNT_W'(skt_pkg::DEPTH));
    assign key_eq   = (key_reg == rd_data);
    assign key_lt   = (key_reg < rd_data);
    assign need_ins = (act_reg == skt_pkg::ACT_INS_SORT)
                   || ((act_reg == skt_pkg::ACT_INS_UNIQ) && !hit_reg);

    always_comb
    begin
        unique case (act_reg) inside
            skt_pkg::ACT_APPEND:                    dec_err = full;
            skt_pkg::ACT_INS_AT:                    dec_err = (pos_ext > cnt_ext) || full;
            skt_pkg::ACT_REMOVE, skt_pkg::ACT_READ: dec_err = (pos_ext >= cnt_ext);
            default:                                dec_err = 1'b0;
        endcase
    end

    always_comb
    begin
        sts.act       = act_reg;
        sts.dec_err   = dec_err;
        sts.full      = full;
        sts.need_ins  = need_ins;
        sts.srch_open = (lo_reg < hi_reg);
        sts.srch_hit  = key_eq;
        sts.up_more   = (idx_ext > where_reg);
        sts.dn_more   = (idx_inc < {1'b0, count_reg});
    end

    always_comb
    begin
        act_next    = act_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        where_next  = where_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        rkey_next   = rkey_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg[skt_pkg::IDX_W-1:0];
        wr_data     = rd_data;
        rd_en       = 1'b0;
        rd_addr     = mid[skt_pkg::IDX_W-1:0];

        unique case (cmd.op)
            skt_pkg::OP_NONE:
            begin
            end
            skt_pkg::OP_LATCH:
            begin
                act_next    = in_action;
                pos_next    = in_position;
                key_next    = in_key[skt_pkg::KEY_W-1:0];
                status_next = 1'b0;
                hit_next    = 1'b0;
                rkey_next   = '0;
            end
            skt_pkg::OP_DECODE:
            begin
                status_next = dec_err;
                lo_next     = '0;
                hi_next     = count_reg;
                idx_next    = count_reg;
                where_next  = '0;
                unique case (act_reg) inside
                    skt_pkg::ACT_APPEND:
                    begin
                        where_next = cnt_ext;
                    end
                    skt_pkg::ACT_INS_AT, skt_pkg::ACT_READ:
                    begin
                        where_next = pos_ext;
                    end
                    skt_pkg::ACT_REMOVE:
                    begin
                        where_next = pos_ext;
                        idx_next   = pos_ext[skt_pkg::CNT_W-1:0];
                    end
                    skt_pkg::ACT_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            skt_pkg::OP_SRCH_ADDR:
            begin
                rd_en   = (lo_reg < hi_reg);
                rd_addr = mid[skt_pkg::IDX_W-1:0];
                if (!(lo_reg < hi_reg))
                begin
                    where_next = skt_pkg::cmp_t'(lo_reg);
                    hit_next   = 1'b0;
                end
            end
            skt_pkg::OP_SRCH_CMP:
            begin
                if (key_eq)
                begin
                    where_next = skt_pkg::cmp_t'(mid);
                    hit_next   = 1'b1;
                end
                else if (key_lt)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = skt_pkg::CNT_W'(mid + 1'b1);
                end
            end
            skt_pkg::OP_SRCH_DONE:
            begin
                idx_next = count_reg;
                if (act_reg == skt_pkg::ACT_INS_SORT)
                begin
                    hit_next = 1'b0;
                end
                if (need_ins && full)
                begin
                    status_next = 1'b1;
                end
            end
            skt_pkg::OP_UP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = skt_pkg::IDX_W'(idx_reg - 1'b1);
            end
            skt_pkg::OP_UP_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[skt_pkg::IDX_W-1:0];
                wr_data  = rd_data;
                idx_next = idx_reg - 1'b1;
            end
            skt_pkg::OP_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = where_reg[skt_pkg::IDX_W-1:0];
                wr_data    = key_reg;
                count_next = count_reg + 1'b1;
            end
            skt_pkg::OP_DN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_inc[skt_pkg::IDX_W-1:0];
            end
            skt_pkg::OP_DN_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[skt_pkg::IDX_W-1:0];
                wr_data  = rd_data;
                idx_next = idx_inc[skt_pkg::CNT_W-1:0];
            end
            skt_pkg::OP_REM_END:
            begin
                count_next = count_reg - 1'b1;
            end
            skt_pkg::OP_RD_ADDR:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_ext[skt_pkg::IDX_W-1:0];
            end
            skt_pkg::OP_RD_CAP:
            begin
                rkey_next = rd_data;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // working and result words carry no reset
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        where_reg  <= where_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
        rkey_reg   <= rkey_next;
        if (cmd.op == skt_pkg::OP_OUT_LOAD)
        begin
            out_status_reg   <= status_reg;
            out_found_reg    <= hit_reg;
            out_where_reg    <= where_reg[skt_pkg::WHERE_W-1:0];
            out_read_key_reg <= skt_pkg::KEY_FIELD_W'(rkey_reg);
            out_total_reg    <= cnt_ext[skt_pkg::TOTAL_W-1:0];
        end
    end

    assign out_status   = out_status_reg;
    assign out_found    = out_found_reg;
    assign out_where    = out_where_reg;
    assign out_read_key = out_read_key_reg;
    assign out_total    = out_total_reg;

endmodule

FILE: rtl/core/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl: request sequencer of the sorted key table
// Steps each request through decode, search probes, entry moves and the
// hand-over to the result register.
// ----------------------------------------------------------------------------
module skt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output skt_pkg::dp_cmd_t cmd,
    input  skt_pkg::dp_sts_t sts
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [ST_W-1:0] ST_DECODE    = 4'd1;
    localparam logic [ST_W-1:0] ST_SRCH_ADDR = 4'd2;
    localparam logic [ST_W-1:0] ST_SRCH_CMP  = 4'd3;
    localparam logic [ST_W-1:0] ST_SRCH_DONE = 4'd4;
    localparam logic [ST_W-1:0] ST_INS_CHK   = 4'd5;
    localparam logic [ST_W-1:0] ST_UP_RD     = 4'd6;
    localparam logic [ST_W-1:0] ST_UP_WR     = 4'd7;
    localparam logic [ST_W-1:0] ST_INS_WR    = 4'd8;
    localparam logic [ST_W-1:0] ST_REM_CHK   = 4'd9;
    localparam logic [ST_W-1:0] ST_DN_RD     = 4'd10;
    localparam logic [ST_W-1:0] ST_DN_WR     = 4'd11;
    localparam logic [ST_W-1:0] ST_RD_ADDR   = 4'd12;
    localparam logic [ST_W-1:0] ST_RD_CAP    = 4'd13;
    localparam logic [ST_W-1:0] ST_FINISH    = 4'd14;

    logic [ST_W-1:0] state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = skt_pkg::OP_NONE;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = skt_pkg::OP_LATCH;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.op = skt_pkg::OP_DECODE;
                unique case (sts.act) inside
                    skt_pkg::ACT_APPEND, skt_pkg::ACT_INS_AT:
                    begin
                        state_next = sts.dec_err ? ST_FINISH : ST_INS_CHK;
                    end
                    skt_pkg::ACT_INS_SORT, skt_pkg::ACT_INS_UNIQ, skt_pkg::ACT_SEARCH:
                    begin
                        state_next = ST_SRCH_ADDR;
                    end
                    skt_pkg::ACT_REMOVE:
                    begin
                        state_next = sts.dec_err ? ST_FINISH : ST_REM_CHK;
                    end
                    skt_pkg::ACT_READ:
                    begin
                        state_next = sts.dec_err ? ST_FINISH : ST_RD_ADDR;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SRCH_ADDR:
            begin
                cmd.op     = skt_pkg::OP_SRCH_ADDR;
                state_next = sts.srch_open ? ST_SRCH_CMP : ST_SRCH_DONE;
            end
            ST_SRCH_CMP:
            begin
                cmd.op     = skt_pkg::OP_SRCH_CMP;
                state_next = sts.srch_hit ? ST_SRCH_DONE : ST_SRCH_ADDR;
            end
            ST_SRCH_DONE:
            begin
                cmd.op     = skt_pkg::OP_SRCH_DONE;
                state_next = (!sts.need_ins || sts.full) ? ST_FINISH : ST_INS_CHK;
            end
            ST_INS_CHK:
            begin
                state_next = sts.up_more ? ST_UP_RD : ST_INS_WR;
            end
            ST_UP_RD:
            begin
                cmd.op     = skt_pkg::OP_UP_RD;
                state_next = ST_UP_WR;
            end
            ST_UP_WR:
            begin
                cmd.op     = skt_pkg::OP_UP_WR;
                state_next = ST_INS_CHK;
            end
            ST_INS_WR:
            begin
                cmd.op     = skt_pkg::OP_INS_WR;
                state_next = ST_FINISH;
            end
            ST_REM_CHK:
            begin
                if (sts.dn_more)
                begin
                    state_next = ST_DN_RD;
                end
                else
                begin
                    cmd.op     = skt_pkg::OP_REM_END;
                    state_next = ST_FINISH;
                end
            end
            ST_DN_RD:
            begin
                cmd.op     = skt_pkg::OP_DN_RD;
                state_next = ST_DN_WR;
            end
            ST_DN_WR:
            begin
                cmd.op     = skt_pkg::OP_DN_WR;
                state_next = ST_REM_CHK;
            end
            ST_RD_ADDR:
            begin
                cmd.op     = skt_pkg::OP_RD_ADDR;
                state_next = ST_RD_CAP;
            end
            ST_RD_CAP:
            begin
                cmd.op     = skt_pkg::OP_RD_CAP;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = skt_pkg::OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: ordered table of fixed-width keys with a live count
// Append, insert at, sorted insert, unique sorted insert, remove, read,
// binary search and clear over a single-port-pair key RAM.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  req      in   action, position, key
//  rsp      out  status, found, where_index, read_key, entry_total
//
//  one request at a time; latched in IDLE, decoded in DECODE, handed over in FINISH
//  search: each probe is a registered RAM read in SRCH_ADDR and a compare in
//  SRCH_CMP, at most log2(DEPTH)+1 probes; a match closes to SRCH_DONE at once
//  insert: INS_CHK, UP_RD, UP_WR per shifted entry, then INS_WR; remove: REM_CHK,
//  DN_RD, DN_WR per entry; read: RD_ADDR then RD_CAP; clear and index errors go
//  straight to FINISH; hand-over waits for rsp. reset clears the count and control only; no clearing pass over the RAM
module sorted_key_table (
    input  logic clk,
    input  logic rst_n,
    skt_req_if.sink   req,
    skt_rsp_if.source rsp
);

    skt_pkg::dp_cmd_t cmd;
    skt_pkg::dp_sts_t sts;

    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    skt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_action    (req.action),
        .in_position  (req.position),
        .in_key       (req.key),
        .out_status   (rsp.status),
        .out_found    (rsp.found),
        .out_where    (rsp.where_index),
        .out_read_key (rsp.read_key),
        .out_total    (rsp.entry_total)
    );

    // one request in flight
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in progress");

    // an error never reports a match
    a_err_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.status && rsp.found))
        else $error("result with both error and found");

    // live count bounded by table depth
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (skt_pkg::cmp_t'(rsp.entry_total) <= skt_pkg::cmp_t'(skt_pkg::DEPTH)))
        else $error("entry total beyond table depth");

    // a result word is loaded only once the previous one has been taken
    a_result_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == skt_pkg::OP_OUT_LOAD) |-> (!rsp.valid || rsp.ready))
        else $error("result overwritten before it was taken");

endmodule

FILE: bench/sorted_key_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_test: self-checking bench for the sorted key table
// Drives requests on the req channel with random gaps, holds rsp ready low in
// random bursts, predicts every result from a local copy of the table and
// compares each returned word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_key_table_test;

    import skt_pkg::*;

    typedef struct packed {
        logic       status;
        logic       found;
        where_t     where_index;
        key_field_t read_key;
        total_t     entry_total;
    } table_result_t;

    logic clk;
    logic rst_n;

    skt_req_if req_ch ();
    skt_rsp_if rsp_ch ();

    sorted_key_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    key_t          table_keys [DEPTH];
    int unsigned   table_total;
    table_result_t pending_results [$];

    int idle_pct;
    int mismatches;
    int requests_sent;
    int results_seen;
    int rejected_count;
    int hit_count;
    int peak_total;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // table predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned probe_table(key_t k, output bit hit);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo  = 0;
        hi  = table_total;
        hit = 1'b0;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (k < table_keys[mid])
                hi = mid;
            else if (k == table_keys[mid])
            begin
                hit = 1'b1;
                return mid;
            end
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic bit store_key(int unsigned at, key_t k);
        if (at > table_total || table_total >= DEPTH)
            return 1'b0;
        for (int unsigned i = table_total; i > at; i--)
            table_keys[i] = table_keys[i - 1];
        table_keys[at] = k;
        table_total++;
        if (table_total > peak_total)
            peak_total = table_total;
        return 1'b1;
    endfunction

    function automatic table_result_t apply_request(action_t act, pos_t pos,
                                                    key_field_t key_in);
        table_result_t r;
        key_t          k;
        int unsigned   at;
        bit            hit;
        r   = '0;
        k   = key_in[KEY_W-1:0];
        at  = 0;
        hit = 1'b0;
        case (act)
            ACT_APPEND:
            begin
                at       = table_total;
                r.status = !store_key(table_total, k);
            end
            ACT_INS_AT:
            begin
                at       = pos;
                r.status = !store_key(pos, k);
            end
            ACT_INS_SORT:
            begin
                at       = probe_table(k, hit);
                hit      = 1'b0;
                r.status = !store_key(at, k);
            end
            ACT_INS_UNIQ:
            begin
                at = probe_table(k, hit);
                if (!hit)
                    r.status = !store_key(at, k);
            end
            ACT_REMOVE:
            begin
                at = pos;
                if (pos >= table_total)
                    r.status = 1'b1;
                else
                begin
                    for (int unsigned i = pos; i + 1 < table_total; i++)
                        table_keys[i] = table_keys[i + 1];
                    table_total--;
                end
            end
            ACT_READ:
            begin
                at = pos;
                if (pos >= table_total)
                    r.status = 1'b1;
                else
                    r.read_key = key_field_t'(table_keys[pos]);
            end
            ACT_SEARCH:
                at = probe_table(k, hit);
            default:
                table_total = 0;
        endcase
        r.found       = hit;
        r.where_index = at[WHERE_W-1:0];
        r.entry_total = table_total[TOTAL_W-1:0];
        if (r.status)
            rejected_count++;
        if (hit)
            hit_count++;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic send_request(action_t act, pos_t pos, key_field_t key_in);
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 3);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.key      <= key_in;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_results.push_back(apply_request(act, pos, key_in));
        requests_sent++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && $urandom_range(0, 99) < idle_pct)
                stall_left = $urandom_range(1, 3);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result word with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, rsp_ch.status);
                check_field("found", want.found, rsp_ch.found);
                check_field("where_index", want.where_index, rsp_ch.where_index);
                check_field("read_key", want.read_key, rsp_ch.read_key);
                check_field("entry_total", want.entry_total, rsp_ch.entry_total);
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_empty_table();
        send_request(ACT_READ, 0, 32'h0000_0001);
        send_request(ACT_REMOVE, 0, 32'h0000_0000);
        send_request(ACT_SEARCH, 0, 32'h0000_0005);
        send_request(ACT_INS_AT, 1, 32'h1234_5678);
        send_request(ACT_INS_AT, 7'h7f, 32'hffff_ffff);
        send_request(ACT_APPEND, 0, 32'hffff_ffff);
        send_request(ACT_INS_AT, 0, 32'h0000_0000);
        send_request(ACT_INS_SORT, 0, 32'h8000_0000);
        send_request(ACT_INS_UNIQ, 0, 32'h8000_0000);
        send_request(ACT_INS_UNIQ, 0, 32'h7fff_ffff);
        send_request(ACT_SEARCH, 0, 32'hffff_ffff);
        send_request(ACT_SEARCH, 0, 32'h0000_0000);
        send_request(ACT_SEARCH, 0, 32'h9000_0000);
        send_request(ACT_READ, 3, 32'h0000_0000);
        send_request(ACT_READ, 4, 32'h0000_0000);
        send_request(ACT_REMOVE, 1, 32'h0000_0000);
        send_request(ACT_REMOVE, 3, 32'h0000_0000);
        send_request(ACT_INS_SORT, 0, 32'h0000_0000);
        send_request(ACT_SEARCH, 0, 32'h0000_0000);
        send_request(ACT_APPEND, 0, 32'h5555_5555);
        send_request(ACT_INS_AT, 5, 32'haaaa_aaaa);
        send_request(ACT_CLEAR, 7'h7f, 32'hffff_ffff);
        send_request(ACT_READ, 0, 32'h0000_0000);
        send_request(ACT_SEARCH, 0, 32'h0000_0000);
    endtask

    task automatic test_full_table();
        key_field_t next_key;
        next_key = $urandom_range(0, 255);
        send_request(ACT_CLEAR, 0, 32'h0000_0000);
        for (int i = 0; i < DEPTH; i++)
        begin
            send_request(ACT_APPEND, 0, next_key);
            next_key += $urandom_range(1, 32'h0300_0000);
        end
        send_request(ACT_APPEND, 0, next_key);
        send_request(ACT_INS_AT, 0, 32'h0000_0000);
        send_request(ACT_INS_AT, pos_t'(DEPTH + 1), 32'h0000_0000);
        send_request(ACT_INS_SORT, 0, table_keys[17] + 1);
        send_request(ACT_INS_UNIQ, 0, table_keys[40]);
        send_request(ACT_INS_UNIQ, 0, table_keys[10] + 1);
        send_request(ACT_READ, pos_t'(DEPTH - 1), 32'h0000_0000);
        send_request(ACT_READ, pos_t'(DEPTH), 32'h0000_0000);
        send_request(ACT_REMOVE, pos_t'(DEPTH - 1), 32'h0000_0000);
        send_request(ACT_INS_AT, 0, 32'h0000_0000);
        send_request(ACT_SEARCH, 0, table_keys[DEPTH - 1]);
        send_request(ACT_REMOVE, 0, 32'h0000_0000);
        send_request(ACT_SEARCH, 0, 32'hffff_ffff);
    endtask

    // mostly sorted inserts, searches and reads; appends and indexed inserts
    // break the ordering now and then
    task automatic run_random(int count, int remove_weight);
        int         r;
        action_t    act;
        pos_t       pos;
        key_field_t key_in;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r == 99)
                act = ($urandom_range(0, 3) == 0) ? ACT_CLEAR : ACT_SEARCH;
            else if (r < 28)
                act = ACT_INS_SORT;
            else if (r < 46)
                act = ACT_INS_UNIQ;
            else if (r < 60)
                act = ACT_SEARCH;
            else if (r < 70)
                act = ACT_READ;
            else if (r < 70 + remove_weight)
                act = ACT_REMOVE;
            else if (r < 70 + remove_weight + (29 - remove_weight) / 2)
                act = ACT_APPEND;
            else
                act = ACT_INS_AT;

            r = $urandom_range(0, 9);
            if (r == 9)
                pos = pos_t'($urandom_range(0, 127));
            else if (r == 8)
                pos = pos_t'(table_total);
            else if (act == ACT_INS_AT)
                pos = pos_t'($urandom_range(0, table_total));
            else
                pos = (table_total == 0) ? '0 : pos_t'($urandom_range(0, table_total - 1));

            r = $urandom_range(0, 9);
            if (r < 4 && table_total > 0)
                key_in = table_keys[$urandom_range(0, table_total - 1)];
            else if (r < 7)
                key_in = $urandom_range(0, 31) * 32'h0800_0001;
            else if (r == 7)
                key_in = $urandom_range(0, 1) ? '1 : '0;
            else
                key_in = $urandom;

            send_request(act, pos, key_in);
        end
    endtask

    initial
    begin
        int waited;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_APPEND;
        req_ch.position = '0;
        req_ch.key      = '0;
        table_total     = 0;
        idle_pct        = 30;
        mismatches      = 0;
        requests_sent   = 0;
        results_seen    = 0;
        rejected_count  = 0;
        hit_count       = 0;
        peak_total      = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_table();
        test_full_table();
        idle_pct = 25;
        run_random(500, 8);
        idle_pct = 15;
        run_random(500, 25);
        idle_pct = 0;
        run_random(400, 12);

        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 50000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            mismatches++;
        end

        $display("%0d requests sent, %0d result words compared, %0d mismatches",
                 requests_sent, results_seen, mismatches);
        $display("%0d requests rejected, %0d key hits, table peaked at %0d entries",
                 rejected_count, hit_count, peak_total);
        if (mismatches == 0)
            $display("sorted_key_table_test passed");
        else
            $display("sorted_key_table_test failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("sorted_key_table_test failed");
        $finish;
    end

endmodule

FILE: sorted_key_table.f
rtl/core/skt_pkg.sv
rtl/core/skt_if.sv
rtl/core/skt_ram.sv
rtl/core/skt_datapath.sv
rtl/core/skt_ctrl.sv
rtl/core/sorted_key_table.sv
bench/sorted_key_table_test.sv
